// ===== rtl/shbq_pkg.sv =====
// Shared types and constants for the side-chain high-pass / low-pass biquad cascade.
// Holds payload structs, register indexes, the sequencer control word and datapath sizes.
// No dependencies.
`timescale 1ns / 1ps

package shbq_pkg;

  // Sample width is fixed by the payload words
  localparam int SAMPLE_BITS         = 24;
  // Feedforward sum x + x2 +/- 2*x1 needs two extra bits
  localparam int FF_BITS             = SAMPLE_BITS + 2;
  // Two's complement accumulator, wraps
  localparam int ACC_BITS            = 64;
  localparam int COEF_FRAC_BITS_DEF  = 22;
  localparam int CFG_INDEX_BITS      = 3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ENABLES = 3'd0,
    REG_HP_B0   = 3'd1,
    REG_HP_A1   = 3'd2,
    REG_HP_A2   = 3'd3,
    REG_LP_B0   = 3'd4,
    REG_LP_A1   = 3'd5,
    REG_LP_A2   = 3'd6
  } cfg_reg_t;

  // Section select
  localparam logic SEC_HP = 1'b0;
  localparam logic SEC_LP = 1'b1;

  // Multiplier operand pair select
  typedef enum logic [1:0] {
    OP_FF  = 2'd0,
    OP_FB1 = 2'd1,
    OP_FB2 = 2'd2
  } op_sel_t;

  // Input word
  typedef struct packed {
    logic                          action;
    logic signed [SAMPLE_BITS-1:0] sample_in;
  } shbq_in_t;

  // Result word
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          clipped;
  } shbq_out_t;

  // Control word from the sequencer to the datapath
  typedef struct packed {
    logic    start;       // load sample, clear clip flag
    logic    clear_hist;  // zero both histories
    logic    ff_en;       // register the feedforward sum
    logic    mul_en;      // register one product
    op_sel_t op;          // which coefficient/data pair
    logic    acc_init;    // acc = product + rounding constant
    logic    acc_sub;     // acc = acc - product
    logic    fin;         // saturate, update history
    logic    sec;         // section in flight
    logic    out_load;    // move result into output register
  } shbq_ctl_t;

endpackage

// ===== rtl/sidechain_hpf_lpf_biquad_cascade.sv =====
// Top level of the side-chain high-pass / low-pass biquad cascade: configuration
// registers, filter history, operand selection and output register.
// Depends on shbq_pkg, shbq_ctrl and shbq_mac.
`timescale 1ns / 1ps

// Each sample runs through an optional direct-form-I high-pass biquad and then an
// optional low-pass biquad (bit0 / bit1 of the enables register), with Q2.COEF_FRAC_BITS
// coefficients b0, a1, a2 per section. All products go through one shared multiplier
// under a small sequencer, three products per enabled section (b0 times the folded
// feedforward sum, a1*y1, a2*y2), so the block takes one word at a time. The result
// is offered once every enabled section has run; the sequencer returns to idle as it
// loads the result into the output register and accepts the next word from there,
// even while that result still waits. A full output register holds the sequencer until
// the waiting result is taken. A clear word zeroes all history in its accept cycle and
// gives no result. Write configuration only while no word is in flight.
module sidechain_hpf_lpf_biquad_cascade #(
  parameter int COEF_FRAC_BITS = shbq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  shbq_pkg::shbq_in_t                       in_data,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output shbq_pkg::shbq_out_t                      out_data,
  input  logic                                     cfg_we,
  input  logic [shbq_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [COEF_FRAC_BITS+1:0]                cfg_wdata
);
  import shbq_pkg::*;

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;

  // Configuration
  logic [1:0]                  enables_r;
  logic [COEF_BITS-2:0]        hp_b0_r, lp_b0_r;
  logic signed [COEF_BITS-1:0] hp_a1_r, hp_a2_r, lp_a1_r, lp_a2_r;

  // History: [0] x[n-1], [1] x[n-2], [2] y[n-1], [3] y[n-2]
  logic signed [SAMPLE_BITS-1:0] hp_h_r [4];
  logic signed [SAMPLE_BITS-1:0] lp_h_r [4];

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic                          clip_r;
  logic signed [FF_BITS-1:0]     ff_r, ff_nxt;
  logic signed [SAMPLE_BITS-1:0] h0, h1, h2, h3;
  logic signed [COEF_BITS-1:0]   op_coef;
  logic signed [FF_BITS-1:0]     op_data;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                          sat;
  logic                          out_valid_r;
  shbq_out_t                     out_data_r;
  shbq_ctl_t                     ctl;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enables_r <= '0;
      hp_b0_r   <= '0;
      hp_a1_r   <= '0;
      hp_a2_r   <= '0;
      lp_b0_r   <= '0;
      lp_a1_r   <= '0;
      lp_a2_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLES: enables_r <= cfg_wdata[1:0];
        REG_HP_B0:   hp_b0_r   <= cfg_wdata[COEF_BITS-2:0];
        REG_HP_A1:   hp_a1_r   <= cfg_wdata;
        REG_HP_A2:   hp_a2_r   <= cfg_wdata;
        REG_LP_B0:   lp_b0_r   <= cfg_wdata[COEF_BITS-2:0];
        REG_LP_A1:   lp_a1_r   <= cfg_wdata;
        REG_LP_A2:   lp_a2_r   <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  shbq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .action    (in_data.action),
    .enables   (enables_r),
    .out_valid (out_valid_r),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .ctl       (ctl)
  );

  // Pick the history of the section in flight
  assign h0 = (ctl.sec == SEC_LP) ? lp_h_r[0] : hp_h_r[0];
  assign h1 = (ctl.sec == SEC_LP) ? lp_h_r[1] : hp_h_r[1];
  assign h2 = (ctl.sec == SEC_LP) ? lp_h_r[2] : hp_h_r[2];
  assign h3 = (ctl.sec == SEC_LP) ? lp_h_r[3] : hp_h_r[3];

  // Feedforward sum: high-pass subtracts 2*x1, low-pass adds it
  always_comb begin
    if (ctl.sec == SEC_LP) begin
      ff_nxt = FF_BITS'(x_r) + FF_BITS'(h1) + (FF_BITS'(h0) <<< 1);
    end else begin
      ff_nxt = FF_BITS'(x_r) + FF_BITS'(h1) - (FF_BITS'(h0) <<< 1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ff_en) begin
      ff_r <= ff_nxt;
    end
  end

  // Select multiplier operands
  always_comb begin
    unique case (ctl.op)
      OP_FF: begin
        op_coef = (ctl.sec == SEC_LP) ? signed'({1'b0, lp_b0_r}) : signed'({1'b0, hp_b0_r});
        op_data = ff_r;
      end
      OP_FB1: begin
        op_coef = (ctl.sec == SEC_LP) ? lp_a1_r : hp_a1_r;
        op_data = FF_BITS'(h2);
      end
      OP_FB2: begin
        op_coef = (ctl.sec == SEC_LP) ? lp_a2_r : hp_a2_r;
        op_data = FF_BITS'(h3);
      end
      default: begin
        op_coef = '0;
        op_data = '0;
      end
    endcase
  end

  shbq_mac #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .ctl     (ctl),
    .op_coef (op_coef),
    .op_data (op_data),
    .y       (y),
    .sat     (sat)
  );

  // Hold the running sample and clip flag
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r    <= in_data.sample_in;
      clip_r <= 1'b0;
    end else if (ctl.fin) begin
      x_r    <= y;
      clip_r <= clip_r | sat;
    end
  end

  // Shift history of the finished section; clear on request
  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear_hist) begin
      for (int i = 0; i < 4; i++) begin
        hp_h_r[i] <= '0;
        lp_h_r[i] <= '0;
      end
    end else if (ctl.fin) begin
      if (ctl.sec == SEC_LP) begin
        lp_h_r[1] <= lp_h_r[0];
        lp_h_r[0] <= x_r;
        lp_h_r[3] <= lp_h_r[2];
        lp_h_r[2] <= y;
      end else begin
        hp_h_r[1] <= hp_h_r[0];
        hp_h_r[0] <= x_r;
        hp_h_r[3] <= hp_h_r[2];
        hp_h_r[2] <= y;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data_r.sample_out <= x_r;
      out_data_r.clipped    <= clip_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/shbq_mac.sv =====
// Shared multiply-accumulate unit of the biquad cascade, with rounding and saturation.
// One signed product per cycle into a product register, accumulated the cycle after.
// Depends on shbq_pkg.
`timescale 1ns / 1ps

module shbq_mac #(
  parameter int COEF_FRAC_BITS = shbq_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  shbq_pkg::shbq_ctl_t                      ctl,
  input  logic signed [COEF_FRAC_BITS+1:0]         op_coef,
  input  logic signed [shbq_pkg::FF_BITS-1:0]      op_data,
  output logic signed [shbq_pkg::SAMPLE_BITS-1:0]  y,
  output logic                                     sat
);
  import shbq_pkg::*;

  localparam int COEF_BITS = COEF_FRAC_BITS + 2;
  localparam int PROD_BITS = COEF_BITS + FF_BITS;
  localparam logic signed [ACC_BITS-1:0] ROUND = ACC_BITS'(1) << (COEF_FRAC_BITS - 1);

  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [ACC_BITS-1:0]  acc_r;
  logic signed [ACC_BITS-1:0]  prod_ext;
  logic signed [ACC_BITS-1:0]  shifted;
  logic [ACC_BITS-SAMPLE_BITS:0] hi_bits;
  logic                        fits;

  // Register one product
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_coef * op_data;
    end
  end

  assign prod_ext = ACC_BITS'(prod_r);

  // Accumulate, wrapping at the accumulator width
  always_ff @(posedge clk) begin
    if (ctl.acc_init) begin
      acc_r <= prod_ext + ROUND;
    end else if (ctl.acc_sub) begin
      acc_r <= acc_r - prod_ext;
    end
  end

  // Drop fraction bits, then clamp to the sample range
  assign shifted = acc_r >>> COEF_FRAC_BITS;
  assign hi_bits = shifted[ACC_BITS-1:SAMPLE_BITS-1];
  assign fits    = (&hi_bits) | ~(|hi_bits);
  assign sat     = ~fits;
  assign y       = fits ? shifted[SAMPLE_BITS-1:0]
                        : {shifted[ACC_BITS-1], {(SAMPLE_BITS-1){~shifted[ACC_BITS-1]}}};

endmodule

// ===== rtl/shbq_ctrl.sv =====
// Sequencer of the biquad cascade: steps the shared multiply-accumulate unit
// through the enabled sections and hands the result to the output register. Depends on shbq_pkg.
`timescale 1ns / 1ps

module shbq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                action,
  input  logic [1:0]          enables,
  input  logic                out_valid,
  input  logic                out_ready,
  output logic                in_ready,
  output shbq_pkg::shbq_ctl_t ctl
);
  import shbq_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_FF   = 8'b0000_0010,
    ST_MB   = 8'b0000_0100,
    ST_MA1  = 8'b0000_1000,
    ST_MA2  = 8'b0001_0000,
    ST_ACC  = 8'b0010_0000,
    ST_SAT  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   sec_r, sec_nxt;
  logic   out_free;

  assign out_free = ~out_valid | out_ready;

  // Next state and control word
  always_comb begin
    state_nxt = state_r;
    sec_nxt   = sec_r;
    in_ready  = 1'b0;
    ctl       = '0;
    ctl.op    = OP_FF;
    ctl.sec   = sec_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (action) begin
            ctl.clear_hist = 1'b1;
          end else begin
            ctl.start = 1'b1;
            priority if (enables[0]) begin
              sec_nxt   = SEC_HP;
              state_nxt = ST_FF;
            end else if (enables[1]) begin
              sec_nxt   = SEC_LP;
              state_nxt = ST_FF;
            end else begin
              state_nxt = ST_DONE;
            end
          end
        end
      end
      ST_FF: begin
        ctl.ff_en = 1'b1;
        state_nxt = ST_MB;
      end
      ST_MB: begin
        ctl.mul_en = 1'b1;
        ctl.op     = OP_FF;
        state_nxt  = ST_MA1;
      end
      ST_MA1: begin
        ctl.mul_en   = 1'b1;
        ctl.op       = OP_FB1;
        ctl.acc_init = 1'b1;
        state_nxt    = ST_MA2;
      end
      ST_MA2: begin
        ctl.mul_en  = 1'b1;
        ctl.op      = OP_FB2;
        ctl.acc_sub = 1'b1;
        state_nxt   = ST_ACC;
      end
      ST_ACC: begin
        ctl.acc_sub = 1'b1;
        state_nxt   = ST_SAT;
      end
      ST_SAT: begin
        ctl.fin = 1'b1;
        if ((sec_r == SEC_HP) && enables[1]) begin
          sec_nxt   = SEC_LP;
          state_nxt = ST_FF;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Advance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sec_r   <= SEC_HP;
    end else begin
      state_r <= state_nxt;
      sec_r   <= sec_nxt;
    end
  end

endmodule

// ===== tb/tb_sidechain_hpf_lpf_biquad_cascade.sv =====
// Self-checking testbench for the side-chain high-pass / low-pass biquad cascade.
// Drives directed and random words through the filter sections under changing
// enables and coefficients. Depends on shbq_pkg and sidechain_hpf_lpf_biquad_cascade.
`timescale 1ns / 1ps

module tb_sidechain_hpf_lpf_biquad_cascade;
  import shbq_pkg::*;

  localparam int     FRAC          = COEF_FRAC_BITS_DEF;
  localparam longint ROUND_HALF    = longint'(1) <<< (FRAC - 1);
  localparam longint SAMPLE_TOP    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_BOTTOM = -SAMPLE_TOP - 1;
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = 24'sh7fffff;
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = 24'sh800000;
  localparam int     CYCLE_LIMIT   = 500000;
  localparam int     SETTLE_CYCLES = 20;
  localparam int     PHASES        = 12;
  localparam int     WORDS_PER_PHASE = 70;
  localparam int     MAX_REPORTS   = 40;

  // Word actions and enable codes
  localparam logic       ACT_FILTER = 1'b0;
  localparam logic       ACT_CLEAR  = 1'b1;
  localparam logic [1:0] EN_NONE    = 2'd0;
  localparam logic [1:0] EN_HP      = 2'd1;
  localparam logic [1:0] EN_LP      = 2'd2;
  localparam logic [1:0] EN_BOTH    = 2'd3;
  // Index past the register list: writes land nowhere
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 3'd7;

  // Cookbook designs: 100 Hz high-pass and 5 kHz low-pass at 48 kHz, Q = 0.707
  localparam logic [FRAC+1:0] HP_DESIGN_B0 = 24'd4155650;
  localparam logic [FRAC+1:0] HP_DESIGN_A1 = -24'sd8310990;
  localparam logic [FRAC+1:0] HP_DESIGN_A2 = 24'd4117380;
  localparam logic [FRAC+1:0] LP_DESIGN_B0 = 24'd302800;
  localparam logic [FRAC+1:0] LP_DESIGN_A1 = -24'sd4652700;
  localparam logic [FRAC+1:0] LP_DESIGN_A2 = 24'd1669800;

  typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_t;
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_CHOKE, RX_TOGGLE} rx_mode_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [FRAC+1:0]           value;
    shbq_in_t                  word;
    logic                      typed;
    shbq_out_t                 result;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  shbq_in_t                  in_data   = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  shbq_out_t                 out_data;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [FRAC+1:0]           cfg_wdata = '0;

  // Filter model state: coefficients and history per section
  logic [1:0]                    enables;
  logic [FRAC:0]                 sec_b0 [2];
  logic signed [FRAC+1:0]        sec_a1 [2];
  logic signed [FRAC+1:0]        sec_a2 [2];
  logic signed [SAMPLE_BITS-1:0] sec_hist [2][4];

  shbq_out_t pending_results [$];
  stim_row_t stim_rows [$];
  int        mismatches  = 0;
  int        cycle_count = 0;
  int        burst_left  = 0;
  rx_mode_t  stall_mode  = RX_OPEN;
  int        stall_run   = 0;

  sidechain_hpf_lpf_biquad_cascade DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: pick a new stall pattern each time the current run length runs out
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 3));
      stall_run  <= $urandom_range(20, 200);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
      RX_CHOKE: out_ready <= ($urandom_range(0, 7) == 0);
      default:  out_ready <= ~out_ready;
    endcase
  end

  // Compare each delivered word against the oldest expected one
  always @(posedge clk) begin
    shbq_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, got sample_out %0d clipped %0b",
                   $time, out_data.sample_out, out_data.clipped);
      end else begin
        want = pending_results.pop_front();
        if (out_data.sample_out !== want.sample_out) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: sample_out expected %0d got %0d",
                     $time, want.sample_out, out_data.sample_out);
        end
        if (out_data.clipped !== want.clipped) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: clipped expected %0b got %0b",
                     $time, want.clipped, out_data.clipped);
        end
      end
    end
  end

  // One direct-form-I section; shifts its history and flags saturation
  function automatic logic signed [SAMPLE_BITS-1:0] run_section(
      input logic sec, input logic signed [SAMPLE_BITS-1:0] x, inout logic hit);
    longint ff;
    longint acc;
    logic signed [SAMPLE_BITS-1:0] y;
    ff = longint'(x) + longint'(sec_hist[sec][1]);
    if (sec == SEC_HP) ff = ff - 2 * longint'(sec_hist[sec][0]);
    else               ff = ff + 2 * longint'(sec_hist[sec][0]);
    acc = longint'(sec_b0[sec]) * ff
        - longint'(sec_a1[sec]) * longint'(sec_hist[sec][2])
        - longint'(sec_a2[sec]) * longint'(sec_hist[sec][3])
        + ROUND_HALF;
    acc = acc >>> FRAC;
    if (acc > SAMPLE_TOP) begin
      y   = S_MAX;
      hit = 1'b1;
    end else if (acc < SAMPLE_BOTTOM) begin
      y   = S_MIN;
      hit = 1'b1;
    end else begin
      y = acc[SAMPLE_BITS-1:0];
    end
    sec_hist[sec][1] = sec_hist[sec][0];
    sec_hist[sec][0] = x;
    sec_hist[sec][3] = sec_hist[sec][2];
    sec_hist[sec][2] = y;
    return y;
  endfunction

  // Expected result of one filter word through the enabled sections
  function automatic shbq_out_t filter_word(input logic signed [SAMPLE_BITS-1:0] x);
    shbq_out_t r;
    logic hit;
    logic signed [SAMPLE_BITS-1:0] s;
    hit = 1'b0;
    s   = x;
    if (enables[0]) s = run_section(SEC_HP, s, hit);
    if (enables[1]) s = run_section(SEC_LP, s, hit);
    r.sample_out = s;
    r.clipped    = hit;
    return r;
  endfunction

  function automatic void clear_history();
    for (int s = 0; s < 2; s++)
      for (int i = 0; i < 4; i++) sec_hist[s][i] = '0;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [FRAC+1:0] val);
    case (idx)
      REG_ENABLES: enables        = val[1:0];
      REG_HP_B0:   sec_b0[SEC_HP] = val[FRAC:0];
      REG_HP_A1:   sec_a1[SEC_HP] = val;
      REG_HP_A2:   sec_a2[SEC_HP] = val;
      REG_LP_B0:   sec_b0[SEC_LP] = val[FRAC:0];
      REG_LP_A1:   sec_a1[SEC_LP] = val;
      REG_LP_A2:   sec_a2[SEC_LP] = val;
      default: ;
    endcase
  endfunction

  function automatic void add_write(input logic [CFG_INDEX_BITS-1:0] idx,
                                    input logic [FRAC+1:0] val);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_WRITE;
    r.index = idx;
    r.value = val;
    stim_rows.push_back(r);
  endfunction

  function automatic void add_word(input logic action, input int sample,
                                   input logic typed, input int want_sample,
                                   input logic want_clip);
    stim_row_t r;
    r                   = '0;
    r.kind              = ROW_WORD;
    r.word.action       = action;
    r.word.sample_in    = sample[SAMPLE_BITS-1:0];
    r.typed             = typed;
    r.result.sample_out = want_sample[SAMPLE_BITS-1:0];
    r.result.clipped    = want_clip;
    stim_rows.push_back(r);
  endfunction

  // Present one word in bursts with random gaps; predict on acceptance
  task automatic send_word(input shbq_in_t w, input logic typed, input shbq_out_t typed_res);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (w.action == ACT_CLEAR) clear_history();
    else if (typed) begin
      void'(filter_word(w.sample_in));
      pending_results.push_back(typed_res);
    end else begin
      pending_results.push_back(filter_word(w.sample_in));
    end
  endtask

  // Hold the sender until every expected word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [FRAC+1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    apply_reg(idx, val);
  endtask

  initial begin
    shbq_in_t        w;
    logic            writing;
    logic            sec;
    int              mode;
    int              walk;
    logic [FRAC+1:0] b0v;
    logic [FRAC+1:0] a1v;
    logic [FRAC+1:0] a2v;

    enables = EN_NONE;
    for (int s = 0; s < 2; s++) begin
      sec_b0[s] = '0;
      sec_a1[s] = '0;
      sec_a2[s] = '0;
    end
    clear_history();
    writing = 1'b0;
    walk    = 0;

    // Both sections off after reset: words pass straight through
    add_word(ACT_FILTER, 8388607, 1'b1, 8388607, 1'b0);
    add_word(ACT_FILTER, -8388608, 1'b1, -8388608, 1'b0);
    add_word(ACT_FILTER, 0, 1'b1, 0, 1'b0);
    add_word(ACT_FILTER, -1, 1'b1, -1, 1'b0);
    add_word(ACT_CLEAR, 8388607, 1'b0, 0, 1'b0);
    add_word(ACT_FILTER, 5592405, 1'b1, 5592405, 1'b0);
    add_word(ACT_FILTER, -5592406, 1'b1, -5592406, 1'b0);
    // Unity-gain high-pass, no feedback: x - 2*x1 + x2, saturating
    add_write(REG_HP_B0, 24'd4194304);
    add_write(REG_ENABLES, (FRAC+2)'(EN_HP));
    add_word(ACT_FILTER, 8388607, 1'b1, 8388607, 1'b0);
    add_word(ACT_FILTER, -8388608, 1'b1, -8388608, 1'b1);
    add_word(ACT_FILTER, 8388607, 1'b1, 8388607, 1'b1);
    add_word(ACT_CLEAR, 0, 1'b0, 0, 1'b0);
    add_word(ACT_FILTER, 1, 1'b1, 1, 1'b0);
    // Extreme and out-of-range coefficients in both sections
    add_write(REG_HP_B0, 24'd0);
    add_write(REG_HP_A1, 24'h7fffff);
    add_write(REG_HP_A2, 24'hc00000);
    add_write(REG_LP_B0, 24'hffffff);
    add_write(REG_LP_A1, 24'h800000);
    add_write(REG_LP_A2, 24'h400000);
    add_write(REG_ENABLES, (FRAC+2)'(EN_BOTH));
    add_word(ACT_FILTER, 8388607, 1'b0, 0, 1'b0);
    add_word(ACT_FILTER, -8388608, 1'b0, 0, 1'b0);
    add_word(ACT_FILTER, 1234567, 1'b0, 0, 1'b0);
    add_word(ACT_FILTER, 0, 1'b0, 0, 1'b0);
    // Spare index must change nothing; low-pass alone
    add_write(REG_SPARE, 24'hffffff);
    add_write(REG_ENABLES, (FRAC+2)'(EN_LP));
    add_write(REG_LP_A2, 24'h800000);
    add_word(ACT_FILTER, -8388608, 1'b0, 0, 1'b0);
    add_word(ACT_FILTER, 8388607, 1'b0, 0, 1'b0);
    add_word(ACT_CLEAR, -1, 1'b0, 0, 1'b0);
    add_word(ACT_FILTER, 100, 1'b0, 0, 1'b0);
    add_write(REG_ENABLES, (FRAC+2)'(EN_NONE));
    add_word(ACT_FILTER, -8388608, 1'b1, -8388608, 1'b0);
    add_word(ACT_FILTER, 4660, 1'b1, 4660, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; writes only once the block is idle
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_WRITE) begin
        if (!writing) drain_results();
        writing = 1'b1;
        write_reg(stim_rows[i].index, stim_rows[i].value);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing = 1'b0;
        end
        send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].result);
      end
    end

    // Random phases, each with a fresh set of coefficients
    for (int phase = 0; phase < PHASES; phase++) begin
      drain_results();
      for (int s = 0; s < 2; s++) begin
        sec  = 1'(s);
        mode = (phase < 4) ? (phase + s) % 4 : $urandom_range(0, 3);
        case (mode)
          0: begin
            b0v = (sec == SEC_HP) ? HP_DESIGN_B0 : LP_DESIGN_B0;
            a1v = (sec == SEC_HP) ? HP_DESIGN_A1 : LP_DESIGN_A1;
            a2v = (sec == SEC_HP) ? HP_DESIGN_A2 : LP_DESIGN_A2;
          end
          1: begin
            b0v = (FRAC+2)'($urandom());
            a1v = (FRAC+2)'($urandom());
            a2v = (FRAC+2)'($urandom());
          end
          2: begin
            case ($urandom_range(0, 2))
              0:       b0v = '0;
              1:       b0v = 24'd4194304;
              default: b0v = 24'hffffff;
            endcase
            a1v = $urandom_range(0, 1) ? 24'h800000 : 24'h7fffff;
            a2v = $urandom_range(0, 1) ? 24'hc00000 : 24'h400000;
          end
          default: begin
            b0v = (FRAC+2)'($urandom_range(0, 4194304));
            a1v = (FRAC+2)'(int'($urandom_range(0, 8388608)) - 4194304);
            a2v = (FRAC+2)'(int'($urandom_range(0, 2097152)) - 1048576);
          end
        endcase
        write_reg((sec == SEC_HP) ? REG_HP_B0 : REG_LP_B0, b0v);
        write_reg((sec == SEC_HP) ? REG_HP_A1 : REG_LP_A1, a1v);
        write_reg((sec == SEC_HP) ? REG_HP_A2 : REG_LP_A2, a2v);
      end
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, (FRAC+2)'($urandom()));
      write_reg(REG_ENABLES,
                (FRAC+2)'((phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3))));
      cfg_we <= 1'b0;

      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        w.action = ($urandom_range(0, 31) == 0) ? ACT_CLEAR : ACT_FILTER;
        case ($urandom_range(0, 9))
          0, 1, 2, 3: w.sample_in = SAMPLE_BITS'($urandom());
          4, 5:       w.sample_in = SAMPLE_BITS'(int'($urandom_range(0, 8191)) - 4096);
          6: begin
            case ($urandom_range(0, 3))
              0:       w.sample_in = S_MAX;
              1:       w.sample_in = S_MIN;
              2:       w.sample_in = '0;
              default: w.sample_in = '1;
            endcase
          end
          default: begin
            // Random walk stands in for program material
            walk = walk + int'($urandom_range(0, 131072)) - 65536;
            if (walk > SAMPLE_TOP) walk = int'(SAMPLE_TOP);
            if (walk < SAMPLE_BOTTOM) walk = int'(SAMPLE_BOTTOM);
            w.sample_in = walk[SAMPLE_BITS-1:0];
          end
        endcase
        send_word(w, 1'b0, '0);
      end
    end

    drain_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
